### rtl/lsc_pkg.sv
// shared field widths and constants for the line sensor centroid block
package lsc_pkg;

	localparam int SAMPLE_W      = 10;
	localparam int BLACK_TOTAL_W = 7;
	localparam int CENTROID_W    = 14;
	localparam int FRAC_BITS     = 8;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;

	localparam logic LABEL_WHITE = 1'b0;
	localparam logic LABEL_BLACK = 1'b1;

endpackage

### rtl/line_sensor_centroid_core.sv
// line sensor centroid core: thresholding, black accumulation and centroid divider
//
// Each transfer carries one sensor sample and a last flag; exactly one result
// follows per sample. A sample that does not close the frame, or closes a frame
// with no black sample, has its result registered in the cycle after it is
// accepted. A closing sample with black samples runs a restoring divider that
// yields one quotient bit per cycle over the position sum (SUM_W bits wide) with
// 8 fraction bits appended. Input is stalled while the divider runs and while an
// unclaimed result sits in the output register.
module line_sensor_centroid_core import lsc_pkg::*; #(
	parameter int MAX_SENSORS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [SAMPLE_W-1:0]      cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SAMPLE_W-1:0]      sample,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     label,
	output logic                     frame_done,
	output logic [BLACK_TOTAL_W-1:0] black_total,
	output logic                     line_found,
	output logic [CENTROID_W-1:0]    centroid_q8,
	output logic                     too_long
);

	localparam int CNT_W   = $clog2(MAX_SENSORS + 1);
	localparam int SUM_RAW = $clog2(MAX_SENSORS * (MAX_SENSORS - 1) / 2 + 1);
	localparam int SUM_W   = (SUM_RAW > 0) ? SUM_RAW : 1;
	localparam int DW      = SUM_W + FRAC_BITS;
	localparam int STEP_W  = $clog2(DW);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DIV  = 1'b1;

	logic                     state_q;
	logic [SAMPLE_W-1:0]      threshold_q;
	logic [CNT_W-1:0]         pos_q;
	logic [CNT_W-1:0]         black_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     ovf_q;

	logic [CNT_W-1:0]         div_q;
	logic [CNT_W-1:0]         rem_q;
	logic [DW-1:0]            dq_q;
	logic [STEP_W-1:0]        step_q;

	logic                     out_valid_q;
	logic                     label_q;
	logic                     frame_done_q;
	logic [BLACK_TOTAL_W-1:0] black_total_q;
	logic                     line_found_q;
	logic [CENTROID_W-1:0]    centroid_q;
	logic                     too_long_q;

	logic             accept;
	logic             taken;
	logic             lbl;
	logic             in_range;
	logic             hit;
	logic [CNT_W-1:0] new_black;
	logic [SUM_W-1:0] new_sum;
	logic             new_ovf;
	logic [CNT_W:0]   rem_shift;
	logic             q_bit;
	logic [CNT_W-1:0] rem_next;
	logic [DW-1:0]    dq_next;
	logic             div_done;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign taken    = out_valid_q && !out_stall;

	assign lbl       = (sample < threshold_q) ? LABEL_BLACK : LABEL_WHITE;
	assign in_range  = pos_q < CNT_W'(MAX_SENSORS);
	assign hit       = in_range && (lbl == LABEL_BLACK);
	assign new_black = black_q + CNT_W'(hit);
	assign new_sum   = hit ? (sum_q + SUM_W'(pos_q)) : sum_q;
	assign new_ovf   = ovf_q || !in_range;

	// restoring divide step, one quotient bit per cycle
	assign rem_shift = {rem_q, dq_q[DW-1]};
	assign q_bit     = rem_shift >= {1'b0, div_q};
	assign rem_next  = q_bit ? CNT_W'(rem_shift - {1'b0, div_q}) : CNT_W'(rem_shift);
	assign dq_next   = {dq_q[DW-2:0], q_bit};
	assign div_done  = (state_q == S_DIV) && (step_q == STEP_W'(DW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			black_q     <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (taken) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (last) begin
							pos_q   <= '0;
							black_q <= '0;
							sum_q   <= '0;
							ovf_q   <= 1'b0;
							if (new_black != '0) begin
								state_q <= S_DIV;
								step_q  <= '0;
							end else begin
								out_valid_q <= 1'b1;
							end
						end else begin
							if (in_range) begin
								pos_q <= pos_q + CNT_W'(1);
							end
							black_q     <= new_black;
							sum_q       <= new_sum;
							ovf_q       <= new_ovf;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (div_done) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			label_q       <= lbl;
			frame_done_q  <= last;
			black_total_q <= last ? BLACK_TOTAL_W'(new_black) : '0;
			line_found_q  <= last && (new_black != '0);
			too_long_q    <= last && new_ovf;
			centroid_q    <= '0;
			div_q         <= new_black;
			rem_q         <= '0;
			dq_q          <= {new_sum, {FRAC_BITS{1'b0}}};
		end else if (state_q == S_DIV) begin
			rem_q <= rem_next;
			dq_q  <= dq_next;
			if (div_done) begin
				centroid_q <= CENTROID_W'(dq_next);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign label       = label_q;
	assign frame_done  = frame_done_q;
	assign black_total = black_total_q;
	assign line_found  = line_found_q;
	assign centroid_q8 = centroid_q;
	assign too_long    = too_long_q;

endmodule

### rtl/lsc_checker.sv
// port-level checks for the line sensor centroid core
module lsc_checker import lsc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [SAMPLE_W-1:0]      sample,
	input logic                     last,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic                     label,
	input logic                     frame_done,
	input logic [BLACK_TOTAL_W-1:0] black_total,
	input logic                     line_found,
	input logic [CENTROID_W-1:0]    centroid_q8,
	input logic                     too_long
);

	// stalled input transfer holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample) && $stable(last))
		else $error("stalled input changed");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(label) && $stable(frame_done)
			&& $stable(black_total) && $stable(centroid_q8) && $stable(too_long))
		else $error("stalled result changed");

	// summary fields quiet mid-frame
	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> black_total == '0 && !line_found
			&& centroid_q8 == '0 && !too_long)
		else $error("summary field set on a mid-frame result");

	// line found tracks black count
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> line_found == (black_total != '0))
		else $error("line_found disagrees with black_total");

	// no line means zero centroid
	a_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_found |-> centroid_q8 == '0)
		else $error("centroid set without a line");

endmodule

bind line_sensor_centroid_core lsc_checker u_lsc_checker (.*);

### dv/line_sensor_centroid_checker.sv
`timescale 1ns / 1ps
// checker for the line sensor centroid core: predicts each result and compares
module line_sensor_centroid_checker import lsc_pkg::*; #(
	parameter int MAX_SENSORS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [SAMPLE_W-1:0]      cfg_wdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [SAMPLE_W-1:0]      sample,
	input  logic                     last,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     label,
	input  logic                     frame_done,
	input  logic [BLACK_TOTAL_W-1:0] black_total,
	input  logic                     line_found,
	input  logic [CENTROID_W-1:0]    centroid_q8,
	input  logic                     too_long,
	output int                       mismatches,
	output int                       pending,
	output int                       results_seen,
	output int                       frames_seen,
	output int                       overlong_frames,
	output int                       lines_seen
);

	localparam int POS_W = $clog2(MAX_SENSORS + 1);
	localparam int SUM_W = $clog2(MAX_SENSORS * (MAX_SENSORS - 1) / 2 + 2);

	typedef struct packed {
		logic                     label;
		logic                     frame_done;
		logic [BLACK_TOTAL_W-1:0] black_total;
		logic                     line_found;
		logic [CENTROID_W-1:0]    centroid_q8;
		logic                     too_long;
	} sensor_result_t;

	sensor_result_t expected_results[$];

	logic [SAMPLE_W-1:0] threshold     = THRESHOLD_RESET;
	logic [POS_W-1:0]    next_position = '0;
	logic [POS_W-1:0]    dark_tally    = '0;
	logic [SUM_W-1:0]    position_sum  = '0;
	logic                overflowed    = 1'b0;

	function automatic void clear_frame();
		next_position = '0;
		dark_tally    = '0;
		position_sum  = '0;
		overflowed    = 1'b0;
	endfunction

	function automatic sensor_result_t predict_sample(input logic [SAMPLE_W-1:0] s, input logic l);
		sensor_result_t r;
		logic           black;
		r     = '0;
		black = (s < threshold);
		if (next_position < MAX_SENSORS) begin
			if (black) begin
				dark_tally   = dark_tally + 1'b1;
				position_sum = position_sum + next_position;
			end
			next_position = next_position + 1'b1;
		end else begin
			overflowed = 1'b1;
		end
		r.label = black ? LABEL_BLACK : LABEL_WHITE;
		if (l) begin
			r.frame_done  = 1'b1;
			r.black_total = BLACK_TOTAL_W'(dark_tally);
			r.line_found  = (dark_tally != 0);
			if (dark_tally != 0) begin
				r.centroid_q8 = CENTROID_W'((64'(position_sum) << FRAC_BITS) / 64'(dark_tally));
			end
			r.too_long = overflowed;
			clear_frame();
		end
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on %s of result %0d: expected %0d, got %0d",
					field, results_seen, exp_v, act_v);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sensor_result_t want;
		if (!arst_n) begin
			threshold = THRESHOLD_RESET;
			clear_frame();
			expected_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result with nothing expected: label %0d, frame_done %0d",
							label, frame_done);
					end
				end else begin
					want = expected_results.pop_front();
					check_field("label", want.label, label);
					check_field("frame_done", want.frame_done, frame_done);
					check_field("black_total", want.black_total, black_total);
					check_field("line_found", want.line_found, line_found);
					check_field("centroid_q8", want.centroid_q8, centroid_q8);
					check_field("too_long", want.too_long, too_long);
					results_seen++;
					if (want.frame_done) begin
						frames_seen++;
						overlong_frames += want.too_long;
						lines_seen      += want.line_found;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_sample(sample, last));
			end
			if (cfg_we) begin
				threshold = cfg_wdata;
			end
			pending <= expected_results.size();
		end
	end

endmodule

### dv/line_sensor_centroid_core_tb.sv
`timescale 1ns / 1ps
// testbench top for the line sensor centroid core: stimulus, threshold settings and verdict
module line_sensor_centroid_core_tb import lsc_pkg::*; ;

	typedef enum int {FILL_MIXED, FILL_BLACK, FILL_WHITE, FILL_EDGE, FILL_SINGLE} frame_fill_e;

	localparam int ITEM_TARGET = 1450;
	localparam int MAX_SENSORS = 64;
	localparam int N_SETTINGS  = 8;
	localparam logic [SAMPLE_W-1:0] FIXED_SETTINGS [4] = '{10'd0, 10'd1023, 10'd1, 10'd1022};

	logic                     clk       = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [SAMPLE_W-1:0]      cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic [SAMPLE_W-1:0]      sample;
	logic                     last;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     label;
	logic                     frame_done;
	logic [BLACK_TOTAL_W-1:0] black_total;
	logic                     line_found;
	logic [CENTROID_W-1:0]    centroid_q8;
	logic                     too_long;

	int mismatches;
	int pending;
	int results_seen;
	int frames_seen;
	int overlong_frames;
	int lines_seen;

	logic [SAMPLE_W-1:0] tb_threshold  = THRESHOLD_RESET;
	bit                  idle_on       = 1'b0;
	int                  stall_left    = 0;
	int                  items_sent    = 0;
	int                  settings_used = 1;

	line_sensor_centroid_core #(
		.MAX_SENSORS(MAX_SENSORS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.label      (label),
		.frame_done (frame_done),
		.black_total(black_total),
		.line_found (line_found),
		.centroid_q8(centroid_q8),
		.too_long   (too_long)
	);

	line_sensor_centroid_checker #(
		.MAX_SENSORS(MAX_SENSORS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.last           (last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.label          (label),
		.frame_done     (frame_done),
		.black_total    (black_total),
		.line_found     (line_found),
		.centroid_q8    (centroid_q8),
		.too_long       (too_long),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_seen   (results_seen),
		.frames_seen    (frames_seen),
		.overlong_frames(overlong_frames),
		.lines_seen     (lines_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample(input bit want_black);
		if (want_black && tb_threshold != 0) begin
			return SAMPLE_W'($urandom_range(0, tb_threshold - 1));
		end else if (!want_black) begin
			return SAMPLE_W'($urandom_range(tb_threshold, 1023));
		end
		return SAMPLE_W'($urandom_range(0, 1023));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_edge();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return tb_threshold;
			3: return tb_threshold - 1'b1;
			default: return tb_threshold + 1'b1;
		endcase
	endfunction

	task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic l);
		in_valid <= 1'b1;
		sample   <= s;
		last     <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		tb_threshold  = value;
		settings_used++;
	endtask

	task automatic send_frame(input int len, input frame_fill_e fill, input int black_at);
		logic [SAMPLE_W-1:0] s;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_BLACK:  s = pick_sample(1'b1);
				FILL_WHITE:  s = pick_sample(1'b0);
				FILL_EDGE:   s = pick_edge();
				FILL_SINGLE: s = pick_sample(i == black_at);
				default:     s = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(0, 1023))
				                 : pick_sample(1'($urandom_range(0, 1)));
			endcase
			send_item(s, i == len - 1);
		end
	endtask

	task automatic run_frames(input int budget);
		int          first;
		int          r;
		int          len;
		frame_fill_e fill;
		first = items_sent;
		while (items_sent - first < budget) begin
			r = $urandom_range(0, 19);
			if (r < 12) begin
				len = $urandom_range(1, 16);
			end else if (r < 17) begin
				len = $urandom_range(17, MAX_SENSORS - 1);
			end else if (r == 17) begin
				len = MAX_SENSORS;
			end else begin
				len = $urandom_range(MAX_SENSORS + 1, MAX_SENSORS + 24);
			end
			fill = frame_fill_e'($urandom_range(0, 4));
			send_frame(len, fill, int'($urandom_range(0, len - 1)));
		end
	endtask

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [SAMPLE_W-1:0] setting;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		sample    = '0;
		last      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on <= 1'b1;

		// reset threshold: single-sample frames, samples around the threshold, truncated centroid
		send_item(10'd0, 1'b1);
		send_item(10'd1023, 1'b1);
		send_item(10'd511, 1'b0);
		send_item(10'd512, 1'b0);
		send_item(10'd513, 1'b0);
		send_item(10'd1023, 1'b1);
		send_item(10'd700, 1'b0);
		send_item(10'd700, 1'b0);
		send_item(10'd0, 1'b1);
		send_item(10'd1, 1'b0);
		send_item(10'd1022, 1'b0);
		send_item(10'd100, 1'b0);
		send_item(10'd200, 1'b1);

		// full row black, lone black at the far end, frames past capacity
		send_frame(MAX_SENSORS, FILL_BLACK, 0);
		send_frame(MAX_SENSORS, FILL_SINGLE, MAX_SENSORS - 1);
		send_frame(MAX_SENSORS + 6, FILL_BLACK, 0);
		send_frame(MAX_SENSORS + 1, FILL_WHITE, 0);

		for (int p = 0; p < N_SETTINGS; p++) begin
			wait_drained();
			if (p < 4) begin
				setting = FIXED_SETTINGS[p];
			end else if (p == N_SETTINGS - 1) begin
				setting = THRESHOLD_RESET;
			end else begin
				setting = SAMPLE_W'($urandom_range(2, 1021));
			end
			write_threshold(setting);
			idle_on <= (p != 2) && (p != N_SETTINGS - 1);
			run_frames((ITEM_TARGET - items_sent) / (N_SETTINGS - p));
		end

		wait_drained();
		repeat (30) @(posedge clk);
		$display("%0d sample transfers checked in %0d frames: %0d over capacity, %0d with a line",
			results_seen, frames_seen, overlong_frames, lines_seen);
		$display("%0d threshold settings including both extremes, with and without idling",
			settings_used);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### line_sensor_centroid_core.f
rtl/lsc_pkg.sv
rtl/line_sensor_centroid_core.sv
rtl/lsc_checker.sv
dv/line_sensor_centroid_checker.sv
dv/line_sensor_centroid_core_tb.sv
